// File: hw/rtl/cee_pkg.sv
// ----------------------------------------------------------------------------
// cee_pkg
// Shared types, character constants and helpers for the code point escape
// encoder.
// ----------------------------------------------------------------------------
package cee_pkg;

   localparam int CodePointWidth = 21;
   localparam int ByteWidth      = 8;
   localparam int CountWidth     = 4;
   localparam int UnitWidth      = 16;

   localparam logic CSR_ESCAPE_CONTROL   = 1'b0;
   localparam logic CSR_ESCAPE_NON_ASCII = 1'b1;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_A      = 8'h61;

   localparam logic [4:0] CTL_BS = 5'h08;
   localparam logic [4:0] CTL_HT = 5'h09;
   localparam logic [4:0] CTL_LF = 5'h0A;
   localparam logic [4:0] CTL_FF = 5'h0C;
   localparam logic [4:0] CTL_CR = 5'h0D;

   localparam logic [CountWidth-1:0] LEN_UESC   = 4'd6;
   localparam logic [CountWidth-1:0] LEN_UPAIR  = 4'd12;
   localparam logic [CountWidth-1:0] UESC_SPLIT = 4'd6;

   localparam logic [UnitWidth-1:0] HI_SURR_BASE = 16'hD800;
   localparam logic [5:0]           LO_SURR_TAG  = 6'b110111;

   typedef enum logic {
      DESC_BYTES,
      DESC_UESC
   } desc_mode_type;

   // DESC_BYTES: up to four bytes, first byte in the top lane.
   // DESC_UESC: first unit in the top half, second unit in the bottom half.
   typedef struct packed {
      desc_mode_type         mode;
      logic [CountWidth-1:0] count;
      logic [31:0]           data;
   } desc_type;

   typedef struct packed {
      logic escape_control;
      logic escape_non_ascii;
   } cfg_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = CHAR_ZERO + {4'b0, nib};
      end else begin
         ch = CHAR_A + {4'b0, nib - 4'd10};
      end
      return ch;
   endfunction

endpackage

// File: hw/rtl/cee_front.sv
// ----------------------------------------------------------------------------
// cee_front
// Classifies an incoming code point into an output descriptor: raw bytes
// (ASCII, short escapes, UTF-8) or one or two \u escape units.
// ----------------------------------------------------------------------------
module cee_front
   import cee_pkg::*;
(
   input  logic [CodePointWidth-1:0] code_point,
   input  cfg_type                   cfg,
   output desc_type                  desc
);

   logic        is_ascii;
   logic        is_ctl;
   logic        is_c1;
   logic        is_bmp;
   logic [7:0]  letter;
   logic [CodePointWidth-1:0] v;
   logic [UnitWidth-1:0] hi_unit;
   logic [UnitWidth-1:0] lo_unit;

   assign is_ascii = code_point < 21'h80;
   assign is_ctl   = (code_point <= 21'h1F) || (code_point == 21'h7F);
   assign is_c1    = code_point <= 21'h9F;
   assign is_bmp   = code_point < 21'h10000;
   assign v        = code_point - 21'h10000;
   assign hi_unit  = HI_SURR_BASE + {5'b0, v[20:10]};
   assign lo_unit  = {LO_SURR_TAG, v[9:0]};

   always_comb begin
      letter = 8'h00;
      if (code_point <= 21'h1F) begin
         unique case (code_point[4:0])
            CTL_BS:  letter = CHAR_B;
            CTL_FF:  letter = CHAR_F;
            CTL_LF:  letter = CHAR_N;
            CTL_CR:  letter = CHAR_R;
            CTL_HT:  letter = CHAR_T;
            default: letter = 8'h00;
         endcase
      end
   end

   always_comb begin
      desc.mode  = DESC_BYTES;
      desc.count = 4'd1;
      desc.data  = {code_point[7:0], 24'h0};
      if (is_ascii) begin
         if (is_ctl && cfg.escape_control) begin
            if (letter != 8'h00) begin
               desc.count = 4'd2;
               desc.data  = {CHAR_BSLASH, letter, 16'h0};
            end else begin
               desc.mode  = DESC_UESC;
               desc.count = LEN_UESC;
               desc.data  = {code_point[15:0], 16'h0};
            end
         end
      end else if (is_c1 && cfg.escape_control) begin
         desc.mode  = DESC_UESC;
         desc.count = LEN_UESC;
         desc.data  = {code_point[15:0], 16'h0};
      end else if (cfg.escape_non_ascii) begin
         desc.mode = DESC_UESC;
         if (is_bmp) begin
            desc.count = LEN_UESC;
            desc.data  = {code_point[15:0], 16'h0};
         end else begin
            desc.count = LEN_UPAIR;
            desc.data  = {hi_unit, lo_unit};
         end
      end else if (code_point < 21'h800) begin
         desc.count = 4'd2;
         desc.data  = {3'b110, code_point[10:6], 2'b10, code_point[5:0], 16'h0};
      end else if (is_bmp) begin
         desc.count = 4'd3;
         desc.data  = {4'b1110, code_point[15:12], 2'b10, code_point[11:6],
                       2'b10, code_point[5:0], 8'h0};
      end else begin
         desc.count = 4'd4;
         desc.data  = {5'b11110, code_point[20:18], 2'b10, code_point[17:12],
                       2'b10, code_point[11:6], 2'b10, code_point[5:0]};
      end
   end

endmodule

// File: hw/rtl/cee_queue.sv
// ----------------------------------------------------------------------------
// cee_queue
// Small descriptor FIFO between the classifier and the byte emitter.
// ----------------------------------------------------------------------------
module cee_queue
   import cee_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output desc_type head,
   output logic     full,
   output logic     not_empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   desc_type            mem_ff [DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;

   assign full      = cnt_ff == CntW'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("descriptor queue underflow");

endmodule

// File: hw/rtl/cee_back.sv
// ----------------------------------------------------------------------------
// cee_back
// Walks the head descriptor one byte per cycle, unless rsp_stall holds it,
// into the output register and retires it as its last byte is loaded.
// ----------------------------------------------------------------------------
module cee_back
   import cee_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  desc_type   head,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte
);

   logic [CountWidth-1:0] idx_ff, idx_in;
   logic                  valid_ff, valid_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;
   logic                  out_free;
   logic                  load;
   logic                  is_last;
   logic                  second_unit;
   logic [2:0]            pos;
   logic [UnitWidth-1:0]  unit;
   logic [7:0]            cur_byte;

   assign out_free    = !valid_ff || !rsp_stall;
   assign load        = out_free && head_valid;
   assign is_last     = idx_ff == head.count - 4'd1;
   assign pop         = load && is_last;
   assign second_unit = idx_ff >= UESC_SPLIT;
   assign pos         = second_unit ? 3'(idx_ff - UESC_SPLIT) : idx_ff[2:0];
   assign unit        = second_unit ? head.data[15:0] : head.data[31:16];

   always_comb begin
      cur_byte = 8'h00;
      if (head.mode == DESC_BYTES) begin
         case (idx_ff[1:0])
            2'd0:    cur_byte = head.data[31:24];
            2'd1:    cur_byte = head.data[23:16];
            2'd2:    cur_byte = head.data[15:8];
            default: cur_byte = head.data[7:0];
         endcase
      end else begin
         case (pos)
            3'd0:    cur_byte = CHAR_BSLASH;
            3'd1:    cur_byte = CHAR_U;
            3'd2:    cur_byte = hex_char(unit[15:12]);
            3'd3:    cur_byte = hex_char(unit[11:8]);
            3'd4:    cur_byte = hex_char(unit[7:4]);
            default: cur_byte = hex_char(unit[3:0]);
         endcase
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + 4'd1;
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = is_last;
      end else if (out_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_last_byte = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> idx_ff < head.count)
      else $error("byte index beyond descriptor length");

   a_idx_restart: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == '0)
      else $error("byte index not cleared after retire");

   a_last_on_pop: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_last_byte == $past(pop))
      else $error("last marker does not match descriptor retire");

endmodule

// File: hw/rtl/codepoint_escape_encoder.sv
// ----------------------------------------------------------------------------
// codepoint_escape_encoder
// Renders one code point per transaction as JSON-style escaped text or UTF-8,
// one byte per result transaction with the final byte marked.
// ----------------------------------------------------------------------------
// The first byte passes through the descriptor queue and the output register
// before it is presented. Throughput: one byte per cycle while rsp_stall is
// low; an item is 1 to 12 bytes, so printable ASCII keeps one item per cycle.
// Requests are taken while the descriptor queue (QUEUE_DEPTH) has room.
// Reset clears both escape controls, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module codepoint_escape_encoder
   import cee_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CodePointWidth-1:0] req_code_point,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_byte,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic                      csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   desc_type front_desc;
   desc_type head;
   logic     q_full;
   logic     q_not_empty;
   logic     push;
   logic     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ESCAPE_CONTROL:   cfg_in.escape_control   = csr_wdata;
            CSR_ESCAPE_NON_ASCII: cfg_in.escape_non_ascii = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   cee_front u_front (
      .code_point (req_code_point),
      .cfg        (cfg_ff),
      .desc       (front_desc)
   );

   cee_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_desc),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   cee_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (q_not_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule
